FILE: hdl/rmfs_pkg.sv
package rmfs_pkg;

    // Default panel geometry
    localparam int DEF_PANEL_ROWS = 64;
    localparam int DEF_PANEL_COLS = 64;
    localparam int DEF_SCAN_LINES = 32;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int PIXEL_W = 6;
    localparam int COLOR_W = 3;
    localparam int KIND_W  = 2;
    localparam int ROWA_W  = 5;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Color codes
    localparam logic [COLOR_W-1:0] CLR_BLACK  = 3'd0;
    localparam logic [COLOR_W-1:0] CLR_RED    = 3'd1;
    localparam logic [COLOR_W-1:0] CLR_YELLOW = 3'd2;
    localparam logic [COLOR_W-1:0] CLR_GREEN  = 3'd3;
    localparam logic [COLOR_W-1:0] CLR_CYAN   = 3'd4;
    localparam logic [COLOR_W-1:0] CLR_BLUE   = 3'd5;
    localparam logic [COLOR_W-1:0] CLR_PURPLE = 3'd6;
    localparam logic [COLOR_W-1:0] CLR_WHITE  = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic sweep_step;   // write sweep color at sweep address, advance
        logic do_write;     // single pixel write from request
        logic fill_start;   // load sweep base, color and column
        logic issue_read;   // read pixel from store
        logic issue_tick;   // scan step: reads and scan state update
        logic out_load;     // load output register from pending result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic fill_last;
        logic fill_row_ok;
        logic out_free;
    } t_dp_status;

    // Color code to panel RGB bits (bit2 red, bit1 green, bit0 blue)
    function automatic logic [COLOR_W-1:0] color_to_rgb(input logic [COLOR_W-1:0] code);
        logic [COLOR_W-1:0] rgb;
        case (code)
            CLR_BLACK:  rgb = 3'b000;
            CLR_RED:    rgb = 3'b100;
            CLR_YELLOW: rgb = 3'b110;
            CLR_GREEN:  rgb = 3'b010;
            CLR_CYAN:   rgb = 3'b011;
            CLR_BLUE:   rgb = 3'b001;
            CLR_PURPLE: rgb = 3'b101;
            CLR_WHITE:  rgb = 3'b111;
            default:    rgb = 3'b000;
        endcase
        return rgb;
    endfunction

endpackage

FILE: hdl/rmfs_ram.sv
module rmfs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports that hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: hdl/rmfs_ctrl.sv
module rmfs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [rmfs_pkg::FUNC_W-1:0]   i_func,
    input  rmfs_pkg::t_dp_status          i_status,
    output rmfs_pkg::t_dp_cmd             o_cmd,
    output logic                          o_in_stall
);
    import rmfs_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_FILL   = 4'b0100,
        ST_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FUNC_WRITE: o_cmd.do_write = 1'b1;
                        FUNC_FILL: begin
                            if (i_status.fill_row_ok) begin
                                o_cmd.fill_start = 1'b1;
                                n_state          = ST_FILL;
                            end
                        end
                        FUNC_TICK: begin
                            o_cmd.issue_tick = 1'b1;
                            n_state          = ST_RESULT;
                        end
                        FUNC_READ: begin
                            o_cmd.issue_read = 1'b1;
                            n_state          = ST_RESULT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register, clear pass runs first after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output loaded while occupied");

    // Sweep writes never collide with request traffic
    a_sweep_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_step |-> !(o_cmd.do_write || o_cmd.issue_read || o_cmd.issue_tick))
        else $error("sweep overlaps a request");

    // A read or scan step is followed by the result phase
    a_issue_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue_read || o_cmd.issue_tick) |=> (r_state == ST_RESULT))
        else $error("issued read not followed by result phase");

    // Scan state only moves on an accepted request
    a_tick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue_tick |-> (i_in_valid && !o_in_stall))
        else $error("scan step without accepted request");

endmodule

FILE: hdl/rmfs_dp.sv
module rmfs_dp #(
    parameter int PANEL_ROWS = rmfs_pkg::DEF_PANEL_ROWS,
    parameter int PANEL_COLS = rmfs_pkg::DEF_PANEL_COLS,
    parameter int SCAN_LINES = rmfs_pkg::DEF_SCAN_LINES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmfs_pkg::t_dp_cmd              i_cmd,
    output rmfs_pkg::t_dp_status           o_status,
    input  logic [rmfs_pkg::PIXEL_W-1:0]   i_pixel_row,
    input  logic [rmfs_pkg::PIXEL_W-1:0]   i_pixel_col,
    input  logic [rmfs_pkg::COLOR_W-1:0]   i_pixel_color,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [rmfs_pkg::KIND_W-1:0]    o_kind,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_top_rgb,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_bottom_rgb,
    output logic                           o_latch_pulse,
    output logic                           o_display_on,
    output logic [rmfs_pkg::ROWA_W-1:0]    o_row_address,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_read_color
);
    import rmfs_pkg::*;

    localparam int DEPTH  = PANEL_ROWS * PANEL_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int COL_W  = (PANEL_COLS > 1) ? $clog2(PANEL_COLS) : 1;
    localparam int SC_W   = $clog2(PANEL_COLS + 1);
    localparam int LINE_W = (SCAN_LINES > 1) ? $clog2(SCAN_LINES) : 1;
    localparam int BR_W   = $clog2(2 * SCAN_LINES);

    // Scan state
    logic [LINE_W-1:0]  r_scan_line;
    logic [SC_W-1:0]    r_shift_col;
    logic [ROWA_W-1:0]  r_held_row;

    // Sweep (clear pass and row fill)
    logic [AW-1:0]      r_sweep_addr;
    logic [COL_W-1:0]   r_sweep_col;
    logic [COLOR_W-1:0] r_sweep_color;

    // Pending result info
    logic [KIND_W-1:0]  r_p_kind;
    logic [ROWA_W-1:0]  r_p_row;
    logic               r_p_a_zero;
    logic               r_p_b_zero;

    logic               r_out_valid;

    logic               pix_row_ok, pix_col_ok, pix_ok;
    logic [AW-1:0]      row_base, pix_addr;
    logic               top_ok, bot_ok, shifting;
    logic [BR_W-1:0]    bot_row;
    logic [COL_W-1:0]   scan_col;
    logic [AW-1:0]      top_addr, bot_addr;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

    // Address and range decode
    always_comb begin
        pix_row_ok = int'(i_pixel_row) < PANEL_ROWS;
        pix_col_ok = int'(i_pixel_col) < PANEL_COLS;
        pix_ok     = pix_row_ok && pix_col_ok;
        row_base   = AW'(i_pixel_row) * AW'(PANEL_COLS);
        pix_addr   = row_base + AW'(i_pixel_col);
        shifting   = int'(r_shift_col) < PANEL_COLS;
        scan_col   = r_shift_col[COL_W-1:0];
        bot_row    = BR_W'(r_scan_line) + BR_W'(SCAN_LINES);
        top_ok     = int'(r_scan_line) < PANEL_ROWS;
        bot_ok     = int'(bot_row) < PANEL_ROWS;
        top_addr   = AW'(r_scan_line) * AW'(PANEL_COLS) + AW'(scan_col);
        bot_addr   = AW'(bot_row) * AW'(PANEL_COLS) + AW'(scan_col);
    end

    // Frame store port control
    always_comb begin
        ram_we      = i_cmd.sweep_step || (i_cmd.do_write && pix_ok);
        ram_waddr   = i_cmd.sweep_step ? r_sweep_addr : pix_addr;
        ram_wdata   = i_cmd.sweep_step ? r_sweep_color : i_pixel_color;
        ram_re      = i_cmd.issue_read || (i_cmd.issue_tick && shifting);
        if (i_cmd.issue_tick) begin
            ram_raddr_a = top_ok ? top_addr : '0;
        end else begin
            ram_raddr_a = pix_ok ? pix_addr : '0;
        end
        ram_raddr_b = bot_ok ? bot_addr : '0;
    end

    rmfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // Sweep counters; reset sets up the clear pass with black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr  <= '0;
            r_sweep_col   <= '0;
            r_sweep_color <= CLR_BLACK;
        end else if (i_cmd.fill_start) begin
            r_sweep_addr  <= row_base;
            r_sweep_col   <= '0;
            r_sweep_color <= i_pixel_color;
        end else if (i_cmd.sweep_step) begin
            r_sweep_addr  <= r_sweep_addr + AW'(1);
            r_sweep_col   <= r_sweep_col + COL_W'(1);
        end
    end

    // Scan sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_line <= '0;
            r_shift_col <= '0;
            r_held_row  <= '0;
        end else if (i_cmd.issue_tick) begin
            if (shifting) begin
                r_shift_col <= r_shift_col + SC_W'(1);
            end else begin
                r_held_row  <= ROWA_W'(r_scan_line);
                r_shift_col <= '0;
                if (int'(r_scan_line) == SCAN_LINES - 1) begin
                    r_scan_line <= '0;
                end else begin
                    r_scan_line <= r_scan_line + LINE_W'(1);
                end
            end
        end
    end

    // Pending result description, taken when a read or a scan step is issued
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_read) begin
            r_p_kind   <= KIND_READ;
            r_p_row    <= '0;
            r_p_a_zero <= !pix_ok;
            r_p_b_zero <= 1'b1;
        end else if (i_cmd.issue_tick) begin
            if (shifting) begin
                r_p_kind   <= KIND_SHIFT;
                r_p_row    <= r_held_row;
                r_p_a_zero <= !top_ok;
                r_p_b_zero <= !bot_ok;
            end else begin
                r_p_kind   <= KIND_LATCH;
                r_p_row    <= ROWA_W'(r_scan_line);
                r_p_a_zero <= 1'b1;
                r_p_b_zero <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Fields that mean nothing for the result kind are zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kind        <= r_p_kind;
            o_latch_pulse <= (r_p_kind == KIND_LATCH);
            o_display_on  <= (r_p_kind == KIND_SHIFT);
            o_row_address <= r_p_row;
            o_top_rgb     <= ((r_p_kind == KIND_SHIFT) && !r_p_a_zero) ?
                             color_to_rgb(ram_rdata_a) : '0;
            o_bottom_rgb  <= ((r_p_kind == KIND_SHIFT) && !r_p_b_zero) ?
                             color_to_rgb(ram_rdata_b) : '0;
            o_read_color  <= ((r_p_kind == KIND_READ) && !r_p_a_zero) ? ram_rdata_a : '0;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status back to the controller
    always_comb begin
        o_status.clr_last    = (r_sweep_addr == AW'(DEPTH - 1));
        o_status.fill_last   = (r_sweep_col == COL_W'(PANEL_COLS - 1));
        o_status.fill_row_ok = pix_row_ok;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

FILE: hdl/rgb_matrix_frame_scanner_unit.sv
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+--------------------------------------------
// request  | i_in_valid   | o_in_stall   | i_func i_pixel_row i_pixel_col i_pixel_color
// result   | o_out_valid  | i_out_stall  | o_kind o_top_rgb o_bottom_rgb o_latch_pulse
//          |              |              | o_display_on o_row_address o_read_color
//
// Write pixel has no result; read pixel and scan tick go through the registered frame store
// read, then the output register, and wait longer while the output register is held.
// Fill row writes one column per cycle through the single write port.
// After reset a clear pass writes black to all PANEL_ROWS * PANEL_COLS entries, and
// requests are stalled until it ends.
// A stalled result stays in the output register; a new request is taken meanwhile.
module rgb_matrix_frame_scanner_unit #(
    parameter int PANEL_ROWS = rmfs_pkg::DEF_PANEL_ROWS,
    parameter int PANEL_COLS = rmfs_pkg::DEF_PANEL_COLS,
    parameter int SCAN_LINES = rmfs_pkg::DEF_SCAN_LINES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rmfs_pkg::FUNC_W-1:0]    i_func,
    input  logic [rmfs_pkg::PIXEL_W-1:0]   i_pixel_row,
    input  logic [rmfs_pkg::PIXEL_W-1:0]   i_pixel_col,
    input  logic [rmfs_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rmfs_pkg::KIND_W-1:0]    o_kind,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_top_rgb,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_bottom_rgb,
    output logic                           o_latch_pulse,
    output logic                           o_display_on,
    output logic [rmfs_pkg::ROWA_W-1:0]    o_row_address,
    output logic [rmfs_pkg::COLOR_W-1:0]   o_read_color
);
    import rmfs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer
    rmfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    // Frame store, scan state and output register
    rmfs_dp #(
        .PANEL_ROWS (PANEL_ROWS),
        .PANEL_COLS (PANEL_COLS),
        .SCAN_LINES (SCAN_LINES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_color (i_pixel_color),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_top_rgb     (o_top_rgb),
        .o_bottom_rgb  (o_bottom_rgb),
        .o_latch_pulse (o_latch_pulse),
        .o_display_on  (o_display_on),
        .o_row_address (o_row_address),
        .o_read_color  (o_read_color)
    );

endmodule

FILE: tb/sv/rgb_matrix_frame_scanner_unit_tb.sv
module rgb_matrix_frame_scanner_unit_tb;
    import rmfs_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int ROWS            = DEF_PANEL_ROWS;
    localparam int COLS            = DEF_PANEL_COLS;
    localparam int LINES           = DEF_SCAN_LINES;
    localparam int ITEMS_PER_PHASE = 457;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_CYCLES  = 600000;

    // One panel result, fields in port order
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COLOR_W-1:0] top_rgb;
        logic [COLOR_W-1:0] bottom_rgb;
        logic               latch_pulse;
        logic               display_on;
        logic [ROWA_W-1:0]  row_address;
        logic [COLOR_W-1:0] read_color;
    } t_scan_result;

    // One request of the directed table; want is used when typed is set
    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [PIXEL_W-1:0] row;
        logic [PIXEL_W-1:0] col;
        logic [COLOR_W-1:0] color;
        bit                 typed;
        t_scan_result       want;
    } t_scan_request;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [PIXEL_W-1:0]  i_pixel_row;
    logic [PIXEL_W-1:0]  i_pixel_col;
    logic [COLOR_W-1:0]  i_pixel_color;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [KIND_W-1:0]   o_kind;
    logic [COLOR_W-1:0]  o_top_rgb;
    logic [COLOR_W-1:0]  o_bottom_rgb;
    logic                o_latch_pulse;
    logic                o_display_on;
    logic [ROWA_W-1:0]   o_row_address;
    logic [COLOR_W-1:0]  o_read_color;

    // Shadow of the panel state
    logic [COLOR_W-1:0]  frame_shadow [ROWS][COLS];
    int                  scan_line_shadow;
    int                  shift_col_shadow;
    logic [ROWA_W-1:0]   held_row_shadow;

    // Color code to panel bits, red in bit 2
    logic [COLOR_W-1:0]  rgb_of_code [8] = '{3'b000, 3'b100, 3'b110, 3'b010,
                                             3'b011, 3'b001, 3'b101, 3'b111};

    t_scan_result        pending_results [$];
    t_scan_request       directed_steps [$];
    int                  error_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left      = 0;

    rgb_matrix_frame_scanner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_color (i_pixel_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_top_rgb     (o_top_rgb),
        .o_bottom_rgb  (o_bottom_rgb),
        .o_latch_pulse (o_latch_pulse),
        .o_display_on  (o_display_on),
        .o_row_address (o_row_address),
        .o_read_color  (o_read_color)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic t_scan_result mk_result(input logic [KIND_W-1:0] kind,
                                               input logic [COLOR_W-1:0] top,
                                               input logic [COLOR_W-1:0] bottom,
                                               input logic latch, input logic disp,
                                               input logic [ROWA_W-1:0] rowa,
                                               input logic [COLOR_W-1:0] rd);
        return {kind, top, bottom, latch, disp, rowa, rd};
    endfunction

    // Apply one request to the shadow state; returns 1 when it yields a result
    function automatic bit scan_step(input logic [FUNC_W-1:0] func,
                                     input logic [PIXEL_W-1:0] row,
                                     input logic [PIXEL_W-1:0] col,
                                     input logic [COLOR_W-1:0] color,
                                     output t_scan_result res);
        int k;
        res = '0;
        case (func)
            FUNC_WRITE: begin
                frame_shadow[row][col] = color;
                return 1'b0;
            end
            FUNC_FILL: begin
                for (k = 0; k < COLS; k++) frame_shadow[row][k] = color;
                return 1'b0;
            end
            FUNC_READ: begin
                res = mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, frame_shadow[row][col]);
                return 1'b1;
            end
            FUNC_TICK: begin
                if (shift_col_shadow < COLS) begin
                    // shift top-half and bottom-half pixels of this column
                    res = mk_result(KIND_SHIFT,
                        rgb_of_code[frame_shadow[scan_line_shadow][shift_col_shadow]],
                        rgb_of_code[frame_shadow[scan_line_shadow + LINES][shift_col_shadow]],
                        1'b0, 1'b1, held_row_shadow, '0);
                    shift_col_shadow++;
                end else begin
                    // latch the line, blank, move on
                    held_row_shadow = ROWA_W'(scan_line_shadow);
                    res = mk_result(KIND_LATCH, '0, '0, 1'b1, 1'b0, held_row_shadow, '0);
                    scan_line_shadow = (scan_line_shadow + 1) % LINES;
                    shift_col_shadow = 0;
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Offer one request, hold it until taken, then predict its result
    task automatic send_req(input logic [FUNC_W-1:0] func, input logic [PIXEL_W-1:0] row,
                            input logic [PIXEL_W-1:0] col, input logic [COLOR_W-1:0] color,
                            input bit typed, input t_scan_result want);
        t_scan_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_pixel_row   <= row;
        i_pixel_col   <= col;
        i_pixel_color <= color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (scan_step(func, row, col, color, predicted))
            pending_results.push_back(typed ? want : predicted);
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_kind, o_top_rgb, o_bottom_rgb, o_latch_pulse, o_display_on,
                   o_row_address, o_read_color};
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result kind=%0d", got.kind));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_error($sformatf({"mismatch: want kind=%0d top=%b bot=%b latch=%b",
                        " on=%b row=%0d rd=%0d / got kind=%0d top=%b bot=%b latch=%b",
                        " on=%b row=%0d rd=%0d"},
                        want.kind, want.top_rgb, want.bottom_rgb, want.latch_pulse,
                        want.display_on, want.row_address, want.read_color,
                        got.kind, got.top_rgb, got.bottom_rgb, got.latch_pulse,
                        got.display_on, got.row_address, got.read_color));
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int                 r_i;
        int                 c_i;
        int                 phase;
        int                 n;
        int                 pick;
        logic [FUNC_W-1:0]  func;
        logic [PIXEL_W-1:0] row;
        logic [PIXEL_W-1:0] col;
        logic [COLOR_W-1:0] color;
        logic [PIXEL_W-1:0] last_row;
        logic [PIXEL_W-1:0] last_col;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_out_stall   <= 1'b0;
        i_func        <= FUNC_WRITE;
        i_pixel_row   <= '0;
        i_pixel_col   <= '0;
        i_pixel_color <= CLR_BLACK;
        last_row      = '0;
        last_col      = '0;
        for (r_i = 0; r_i < ROWS; r_i++)
            for (c_i = 0; c_i < COLS; c_i++) frame_shadow[r_i][c_i] = CLR_BLACK;
        scan_line_shadow = 0;
        shift_col_shadow = 0;
        held_row_shadow  = '0;

        // Directed table: reset contents, extremes, each color, both halves
        directed_steps.push_back('{FUNC_READ, 6'd0, 6'd0, CLR_BLACK, 1'b1,
            mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, CLR_BLACK)});
        directed_steps.push_back('{FUNC_READ, 6'd63, 6'd63, CLR_WHITE, 1'b1,
            mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, CLR_BLACK)});
        directed_steps.push_back('{FUNC_TICK, 6'd63, 6'd63, CLR_WHITE, 1'b1,
            mk_result(KIND_SHIFT, 3'b000, 3'b000, 1'b0, 1'b1, '0, CLR_BLACK)});
        directed_steps.push_back('{FUNC_WRITE, 6'd0, 6'd1, CLR_WHITE, 1'b0, '0});
        directed_steps.push_back('{FUNC_WRITE, 6'd32, 6'd1, CLR_RED, 1'b0, '0});
        directed_steps.push_back('{FUNC_WRITE, 6'd63, 6'd63, CLR_PURPLE, 1'b0, '0});
        directed_steps.push_back('{FUNC_WRITE, 6'd63, 6'd0, CLR_YELLOW, 1'b0, '0});
        directed_steps.push_back('{FUNC_FILL, 6'd1, 6'd63, CLR_GREEN, 1'b0, '0});
        directed_steps.push_back('{FUNC_FILL, 6'd33, 6'd0, CLR_CYAN, 1'b0, '0});
        directed_steps.push_back('{FUNC_READ, 6'd0, 6'd1, CLR_BLACK, 1'b1,
            mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, CLR_WHITE)});
        directed_steps.push_back('{FUNC_READ, 6'd63, 6'd63, CLR_BLACK, 1'b1,
            mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, CLR_PURPLE)});
        directed_steps.push_back('{FUNC_READ, 6'd1, 6'd40, CLR_BLACK, 1'b1,
            mk_result(KIND_READ, '0, '0, 1'b0, 1'b0, '0, CLR_GREEN)});
        directed_steps.push_back('{FUNC_TICK, 6'd0, 6'd0, CLR_BLACK, 1'b1,
            mk_result(KIND_SHIFT, 3'b111, 3'b100, 1'b0, 1'b1, '0, CLR_BLACK)});
        directed_steps.push_back('{FUNC_WRITE, 6'd0, 6'd2, CLR_BLUE, 1'b0, '0});
        directed_steps.push_back('{FUNC_WRITE, 6'd32, 6'd2, CLR_CYAN, 1'b0, '0});
        directed_steps.push_back('{FUNC_TICK, 6'd21, 6'd42, CLR_RED, 1'b0, '0});
        directed_steps.push_back('{FUNC_READ, 6'd33, 6'd5, CLR_BLACK, 1'b0, '0});
        directed_steps.push_back('{FUNC_FILL, 6'd0, 6'd0, CLR_RED, 1'b0, '0});
        directed_steps.push_back('{FUNC_TICK, 6'd0, 6'd0, CLR_BLACK, 1'b0, '0});
        directed_steps.push_back('{FUNC_WRITE, 6'd31, 6'd63, CLR_WHITE, 1'b0, '0});
        directed_steps.push_back('{FUNC_READ, 6'd31, 6'd63, CLR_BLACK, 1'b0, '0});
        directed_steps.push_back('{FUNC_READ, 6'd63, 6'd0, CLR_BLACK, 1'b0, '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k])
            send_req(directed_steps[k].func, directed_steps[k].row, directed_steps[k].col,
                     directed_steps[k].color, directed_steps[k].typed,
                     directed_steps[k].want);

        // Random part: scan ticks dominate the mix of requests
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // long receiver hold-off while requests keep coming
            if (phase == 0) hold_left = HOLD_CYCLES;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick  = int'($urandom_range(0, 99));
                row   = PIXEL_W'($urandom_range(0, ROWS - 1));
                col   = PIXEL_W'($urandom_range(0, COLS - 1));
                color = COLOR_W'($urandom_range(0, 7));
                if (pick < 3) begin
                    func     = FUNC_WRITE;
                    last_row = row;
                    last_col = col;
                end else if (pick < 5) begin
                    func = FUNC_FILL;
                end else if (pick < 8) begin
                    func = FUNC_READ;
                    if ($urandom_range(0, 1)) begin
                        row = last_row;
                        col = last_col;
                    end
                end else begin
                    func = FUNC_TICK;
                end
                send_req(func, row, col, color, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: rgb_matrix_frame_scanner_unit.f
hdl/rmfs_pkg.sv
hdl/rmfs_ram.sv
hdl/rmfs_ctrl.sv
hdl/rmfs_dp.sv
hdl/rgb_matrix_frame_scanner_unit.sv
tb/sv/rgb_matrix_frame_scanner_unit_tb.sv
